// ===== rtl/core/pwros_pkg.sv =====
// Shared types and constants for the padded window row offset sum block.
`timescale 1ns / 1ps

package pwros_pkg;

   // Default sizing, handed to the top level's parameters
   localparam int DEF_MAX_HEIGHT         = 32;
   localparam int DEF_MAX_WIDTH          = 32;
   localparam int DEF_NUM_GROUPS         = 8;
   localparam int DEF_CHANNELS_PER_GROUP = 8;
   localparam int DEF_MAX_KERNEL         = 7;

   // Address space of the image store never exceeds 16 bits
   localparam int STORE_LIMIT = 65536;

   // Field widths
   localparam int DIM_W    = 6;
   localparam int KER_W    = 3;
   localparam int STRIDE_W = 3;
   localparam int PAD_W    = 2;
   localparam int ACT_W    = 8;
   localparam int POS_W    = 6;
   localparam int GRP_W    = 3;
   localparam int SUM_W    = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 8;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   // Signed window coordinate: position times stride, minus padding
   localparam int HI_W = POS_W + STRIDE_W + 1;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IN_HEIGHT     = 3'd0,
      CSR_IN_WIDTH      = 3'd1,
      CSR_KERNEL_HEIGHT = 3'd2,
      CSR_KERNEL_WIDTH  = 3'd3,
      CSR_STRIDE        = 3'd4,
      CSR_PAD_ROWS      = 3'd5,
      CSR_PAD_COLS      = 3'd6,
      CSR_ZERO_POINT    = 3'd7
   } csr_index_type;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_COMPUTE = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_LIM,
      ST_LOAD_PTR,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } top_state_type;

   typedef enum logic [1:0] {
      W_IDLE,
      W_SETUP_B,
      W_SETUP_C,
      W_WALK
   } walk_state_type;

   // Clamped window geometry seen by the tap walker
   typedef struct packed {
      logic [DIM_W-1:0]    h_img;
      logic [DIM_W-1:0]    w_img;
      logic [KER_W-1:0]    kh;
      logic [KER_W-1:0]    kw;
      logic [STRIDE_W-1:0] stride;
      logic [PAD_W-1:0]    pad_rows;
      logic [PAD_W-1:0]    pad_cols;
   } win_cfg_type;

   // Per-cycle tap status from the walker
   typedef struct packed {
      logic valid;
      logic in_image;
      logic done;
   } tap_status_type;

endpackage

// ===== rtl/core/padded_window_row_offset_sum_top.sv =====
// Top level: activation store, load pointer, configuration and window accumulator.
`timescale 1ns / 1ps

// Load items (tuser 0) write one activation byte at the load pointer in raster
// order (row, column, group, channel); the pointer returns to zero after the
// full configured image. A load item keeps the block busy through the limit
// and pointer update states. Compute items (tuser 1) sum every channel byte of
// one group over the kernel window, adding the zero point per channel for taps
// outside the image, and return one saturated 17-bit sum with its position.
// During the window walk the single read port of the image store gives one
// byte per cycle. The store holds min(MAX_HEIGHT * MAX_WIDTH * NUM_GROUPS *
// CHANNELS_PER_GROUP, 65536) bytes and needs no clearing if the user loads
// entries before they are read; the block itself does not enforce it. A
// finished sum waits in the output register while the next item is taken.
module padded_window_row_offset_sum_top #(
   parameter int MAX_HEIGHT         = pwros_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH          = pwros_pkg::DEF_MAX_WIDTH,
   parameter int NUM_GROUPS         = pwros_pkg::DEF_NUM_GROUPS,
   parameter int CHANNELS_PER_GROUP = pwros_pkg::DEF_CHANNELS_PER_GROUP,
   parameter int MAX_KERNEL         = pwros_pkg::DEF_MAX_KERNEL
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pwros_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pwros_pkg::CSR_DAT_W-1:0]      csr_data,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // activation[7:0], out_row[13:8], out_col[19:14], group_index[22:20], zero[23]
   input  logic [pwros_pkg::REQ_DATA_W-1:0]     req_tdata,
   // opcode[0]
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // row_sum[16:0], sum_row[22:17], sum_col[28:23], zero[31:29]
   output logic [pwros_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import pwros_pkg::*;

   localparam int GC       = NUM_GROUPS * CHANNELS_PER_GROUP;
   localparam int FULL_SZ  = MAX_HEIGHT * MAX_WIDTH * GC;
   localparam int STORE_DEPTH = (FULL_SZ > STORE_LIMIT) ? STORE_LIMIT : FULL_SZ;
   localparam int ADDR_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int LIM_W    = $clog2(63 * 63 * GC + 1);

   top_state_type state_ff, state_in;

   // Configuration registers
   logic [DIM_W-1:0]    in_height_ff, in_width_ff;
   logic [KER_W-1:0]    kernel_height_ff, kernel_width_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [PAD_W-1:0]    pad_rows_ff, pad_cols_ff;
   logic [ACT_W-1:0]    zero_point_ff;

   win_cfg_type    cfg;
   tap_status_type tap;
   logic [ADDR_W-1:0] tap_addr;

   logic [ACT_W-1:0] req_act;
   logic [POS_W-1:0] req_row, req_col;
   logic [GRP_W-1:0] req_grp;
   logic req_accept, store_we, walk_start, out_load;

   logic [ACT_W-1:0]  store_mem [STORE_DEPTH];
   logic [ADDR_W-1:0] ptr_ff;
   logic [ADDR_W:0]   ptr_nxt;
   logic [LIM_W-1:0]  lim_ff;
   logic              ptr_wrap;

   logic [ACT_W-1:0] rd_data_ff, addend;
   logic             tap_d_valid_ff, inside_d_ff;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [SUM_W:0]   acc_sum;
   logic [POS_W-1:0] pos_row_ff, pos_col_ff;

   logic             rsp_tvalid_ff;
   logic [SUM_W-1:0] rsp_sum_ff;
   logic [POS_W-1:0] rsp_row_ff, rsp_col_ff;

   assign req_act = req_tdata[7:0];
   assign req_row = req_tdata[13:8];
   assign req_col = req_tdata[19:14];
   assign req_grp = req_tdata[22:20];

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_height_ff     <= DIM_W'(32);
         in_width_ff      <= DIM_W'(32);
         kernel_height_ff <= KER_W'(3);
         kernel_width_ff  <= KER_W'(3);
         stride_ff        <= STRIDE_W'(1);
         pad_rows_ff      <= PAD_W'(1);
         pad_cols_ff      <= PAD_W'(1);
         zero_point_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_IN_HEIGHT:     in_height_ff     <= csr_data[DIM_W-1:0];
            CSR_IN_WIDTH:      in_width_ff      <= csr_data[DIM_W-1:0];
            CSR_KERNEL_HEIGHT: kernel_height_ff <= csr_data[KER_W-1:0];
            CSR_KERNEL_WIDTH:  kernel_width_ff  <= csr_data[KER_W-1:0];
            CSR_STRIDE:        stride_ff        <= csr_data[STRIDE_W-1:0];
            CSR_PAD_ROWS:      pad_rows_ff      <= csr_data[PAD_W-1:0];
            CSR_PAD_COLS:      pad_cols_ff      <= csr_data[PAD_W-1:0];
            CSR_ZERO_POINT:    zero_point_ff    <= csr_data[ACT_W-1:0];
         endcase
      end
   end

   // Clamp image and kernel sizes to the built limits
   always_comb begin
      cfg.h_img    = (int'(in_height_ff) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : in_height_ff;
      cfg.w_img    = (int'(in_width_ff) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : in_width_ff;
      cfg.kh       = (int'(kernel_height_ff) > MAX_KERNEL) ? KER_W'(MAX_KERNEL)
                                                           : kernel_height_ff;
      cfg.kw       = (int'(kernel_width_ff) > MAX_KERNEL) ? KER_W'(MAX_KERNEL)
                                                          : kernel_width_ff;
      cfg.stride   = stride_ff;
      cfg.pad_rows = pad_rows_ff;
      cfg.pad_cols = pad_cols_ff;
   end

   // Sequencer outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      req_accept = req_tvalid && (state_ff == ST_IDLE);
      store_we   = req_accept && (opcode_type'(req_tuser) == OP_LOAD);
      walk_start = req_accept && (opcode_type'(req_tuser) == OP_COMPUTE);
      out_load   = (state_ff == ST_DONE) && (!rsp_tvalid_ff || rsp_tready);
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (opcode_type'(req_tuser) == OP_LOAD) ? ST_LOAD_LIM : ST_WALK;
            end
         end
         ST_LOAD_LIM: state_in = ST_LOAD_PTR;
         ST_LOAD_PTR: state_in = ST_IDLE;
         ST_WALK:     if (tap.done) state_in = ST_DRAIN;
         ST_DRAIN:    state_in = ST_DONE;
         ST_DONE:     if (out_load) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Image store
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[ptr_ff] <= req_act;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_mem[tap_addr];
   end

   // Load pointer: advance, return to zero past the image or the store
   assign ptr_nxt  = {1'b0, ptr_ff} + (ADDR_W+1)'(1);
   assign ptr_wrap = ptr_nxt[ADDR_W] || (32'(ptr_nxt) >= 32'(lim_ff));

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD_LIM) begin
         lim_ff <= LIM_W'(cfg.h_img * cfg.w_img * GC);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else if (state_ff == ST_LOAD_PTR) begin
         ptr_ff <= ptr_wrap ? '0 : ptr_nxt[ADDR_W-1:0];
      end
   end

   pwros_walker #(
      .NUM_GROUPS         (NUM_GROUPS),
      .CHANNELS_PER_GROUP (CHANNELS_PER_GROUP),
      .ADDR_W             (ADDR_W)
   ) u_walker (
      .clock    (clock),
      .reset    (reset),
      .start    (walk_start),
      .orow     (req_row),
      .ocol     (req_col),
      .grp      (req_grp),
      .cfg      (cfg),
      .tap      (tap),
      .tap_addr (tap_addr)
   );

   // Delay tap flags to line up with the store read data
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_d_valid_ff <= 1'b0;
      end else begin
         tap_d_valid_ff <= tap.valid;
      end
   end

   always_ff @(posedge clock) begin
      inside_d_ff <= tap.in_image;
   end

   // Saturating accumulator
   assign addend  = inside_d_ff ? rd_data_ff : zero_point_ff;
   assign acc_sum = {1'b0, acc_ff} + (SUM_W+1)'(addend);
   assign acc_in  = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];

   always_ff @(posedge clock) begin
      if (walk_start) begin
         acc_ff     <= '0;
         pos_row_ff <= req_row;
         pos_col_ff <= req_col;
      end else if (tap_d_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_sum_ff <= acc_ff;
         rsp_row_ff <= pos_row_ff;
         rsp_col_ff <= pos_col_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'b000, rsp_col_ff, rsp_row_ff, rsp_sum_ff};

endmodule

// ===== rtl/core/pwros_walker.sv =====
// Tap walker: sets up the window origin and steps one store address per cycle.
`timescale 1ns / 1ps

module pwros_walker #(
   parameter int NUM_GROUPS         = pwros_pkg::DEF_NUM_GROUPS,
   parameter int CHANNELS_PER_GROUP = pwros_pkg::DEF_CHANNELS_PER_GROUP,
   parameter int ADDR_W             = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [pwros_pkg::POS_W-1:0]         orow,
   input  logic [pwros_pkg::POS_W-1:0]         ocol,
   input  logic [pwros_pkg::GRP_W-1:0]         grp,
   input  pwros_pkg::win_cfg_type              cfg,
   output pwros_pkg::tap_status_type           tap,
   output logic [ADDR_W-1:0]                   tap_addr
);
   import pwros_pkg::*;

   localparam int GC    = NUM_GROUPS * CHANNELS_PER_GROUP;
   localparam int CH_W  = (CHANNELS_PER_GROUP > 1) ? $clog2(CHANNELS_PER_GROUP) : 1;
   localparam int PIX_W = HI_W + DIM_W + 2;
   localparam int GRP_SPAN = (1 << GRP_W) - 1;
   localparam logic [ADDR_W-1:0] GC_A    = ADDR_W'(GC);
   localparam logic [ADDR_W-1:0] CH_A    = ADDR_W'(CHANNELS_PER_GROUP);
   localparam logic [CH_W-1:0]   CH_LAST = CH_W'(CHANNELS_PER_GROUP - 1);

   walk_state_type state_ff, state_in;

   logic signed [HI_W-1:0] hi0_ff, wi0_ff, hi_ff, wi_ff;
   logic signed [HI_W-1:0] hi0_in, wi0_in;
   logic [GRP_W-1:0]       g_ff, g_mod;
   logic [ADDR_W-1:0]      pix_ff, row_step_ff, row_addr_ff, col_addr_ff, addr_ff;
   logic [ADDR_W-1:0]      base_addr, next_col_addr, next_row_addr;
   logic [KER_W-1:0]       r_ff, s_ff;
   logic [CH_W-1:0]        c_ff;
   logic [POS_W+STRIDE_W-1:0] row_prod, col_prod;
   logic signed [PIX_W-1:0]   pix_full;
   logic in_image, last_chan, last_col, last_row, last_tap, empty;

   // Window origin: position times stride minus padding
   assign row_prod = orow * cfg.stride;
   assign col_prod = ocol * cfg.stride;
   assign hi0_in = $signed({1'b0, row_prod}) - $signed({{(HI_W-PAD_W){1'b0}}, cfg.pad_rows});
   assign wi0_in = $signed({1'b0, col_prod}) - $signed({{(HI_W-PAD_W){1'b0}}, cfg.pad_cols});

   // Fold the group index into range
   always_comb begin
      g_mod = grp;
      for (int k = 0; k < GRP_SPAN; k++) begin
         if (int'(g_mod) >= NUM_GROUPS) begin
            g_mod = g_mod - GRP_W'(NUM_GROUPS);
         end
      end
   end

   // Origin pixel index, wraps with the store address
   assign pix_full = PIX_W'(hi0_ff) * PIX_W'($signed({1'b0, cfg.w_img})) + PIX_W'(wi0_ff);
   assign base_addr     = pix_ff * GC_A + ADDR_W'(g_ff) * CH_A;
   assign next_col_addr = col_addr_ff + GC_A;
   assign next_row_addr = row_addr_ff + row_step_ff;

   // Tap position tests
   assign in_image = !hi_ff[HI_W-1] && !wi_ff[HI_W-1]
                && (hi_ff[HI_W-2:0] < {{(HI_W-1-DIM_W){1'b0}}, cfg.h_img})
                && (wi_ff[HI_W-2:0] < {{(HI_W-1-DIM_W){1'b0}}, cfg.w_img});
   assign last_chan = (c_ff == CH_LAST);
   assign last_col  = (s_ff == cfg.kw - KER_W'(1));
   assign last_row  = (r_ff == cfg.kh - KER_W'(1));
   assign last_tap  = last_chan && last_col && last_row;
   assign empty     = (cfg.kh == '0) || (cfg.kw == '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         W_IDLE:    if (start) state_in = W_SETUP_B;
         W_SETUP_B: state_in = W_SETUP_C;
         W_SETUP_C: state_in = empty ? W_IDLE : W_WALK;
         W_WALK:    if (last_tap) state_in = W_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      tap.valid    = (state_ff == W_WALK);
      tap.in_image = in_image;
      tap.done     = ((state_ff == W_WALK) && last_tap) || ((state_ff == W_SETUP_C) && empty);
      tap_addr     = addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Setup and address stepping
   always_ff @(posedge clock) begin
      unique case (state_ff)
         W_IDLE: begin
            if (start) begin
               hi0_ff <= hi0_in;
               wi0_ff <= wi0_in;
               g_ff   <= g_mod;
            end
         end
         W_SETUP_B: begin
            pix_ff      <= ADDR_W'(pix_full);
            row_step_ff <= ADDR_W'(cfg.w_img) * GC_A;
         end
         W_SETUP_C: begin
            row_addr_ff <= base_addr;
            col_addr_ff <= base_addr;
            addr_ff     <= base_addr;
            hi_ff       <= hi0_ff;
            wi_ff       <= wi0_ff;
            r_ff        <= '0;
            s_ff        <= '0;
            c_ff        <= '0;
         end
         W_WALK: begin
            priority if (!last_chan) begin
               c_ff    <= c_ff + CH_W'(1);
               addr_ff <= addr_ff + ADDR_W'(1);
            end else if (!last_col) begin
               c_ff        <= '0;
               s_ff        <= s_ff + KER_W'(1);
               wi_ff       <= wi_ff + HI_W'(1);
               col_addr_ff <= next_col_addr;
               addr_ff     <= next_col_addr;
            end else if (!last_row) begin
               c_ff        <= '0;
               s_ff        <= '0;
               r_ff        <= r_ff + KER_W'(1);
               hi_ff       <= hi_ff + HI_W'(1);
               wi_ff       <= wi0_ff;
               row_addr_ff <= next_row_addr;
               col_addr_ff <= next_row_addr;
               addr_ff     <= next_row_addr;
            end else begin
               c_ff <= c_ff;
            end
         end
      endcase
   end

endmodule

// ===== rtl/core/pwros_checker.sv =====
// Port-level checks for the window sum block, bound to its top level.
`timescale 1ns / 1ps

module pwros_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [pwros_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic [pwros_pkg::CSR_DAT_W-1:0]   csr_data,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [pwros_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic                              req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [pwros_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import pwros_pkg::*;

   // Hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // A load item keeps the block busy while the pointer advances
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_LOAD)
      |=> !req_tready ##1 !req_tready)
      else $error("item taken during pointer update");

   // A compute item keeps the block busy through origin setup
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_COMPUTE)
      |=> !req_tready ##1 !req_tready ##1 !req_tready)
      else $error("item taken during window setup");

   // A new result appears only as a compute item finishes
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result item without a finished window walk");

endmodule

bind padded_window_row_offset_sum_top pwros_checker u_pwros_checker (.*);
